// File: src/spbm_pkg.sv
// ----------------------------------------------------------------------------
// Spectrum band peak meter package
// Shared widths, constants and types for the band peak meter.
// ----------------------------------------------------------------------------
package spbm_pkg;

  // Field widths of the bin and band channels.
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned MAG_W   = 24;
  localparam int unsigned NUM_W   = 4;
  localparam int unsigned INT_W   = 5;

  // Peak level, floor(magnitude / 200) clamped to 200.
  localparam int unsigned LEVEL_W = 8;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd200;

  // Magnitudes at or above this value always give the clamped level.
  localparam logic [MAG_W-1:0] LEVEL_SAT_MAG = 24'd40200;

  // floor(m / 200) = floor(floor(m / 8) * 5243 / 2^17) for m below 40200.
  localparam int unsigned LVL_X_W   = 13;
  localparam int unsigned LVL_P_W   = 26;
  localparam logic [LVL_X_W-1:0] LEVEL_RECIP = 13'd5243;
  localparam int unsigned LEVEL_SHIFT = 17;

  // floor(y / 199) = floor(y * 5270 / 2^20) for y up to 199 * 16.
  localparam int unsigned INT_RECIP = 5270;
  localparam int unsigned INT_SHIFT = 20;

  // Threshold after reset, and the lowest bin that counts.
  localparam logic [MAG_W-1:0] THRESH_RESET = 24'd2000;
  localparam logic [IDX_W-1:0] FIRST_BIN    = 8'd2;

  // Bands that receive bins, and their upper index edges.
  localparam int unsigned FIX_BANDS = 8;
  localparam int unsigned BAND_W    = 3;
  localparam int unsigned NUM_EDGES = 7;
  localparam logic [IDX_W-1:0] BAND_EDGES [NUM_EDGES] = '{
    8'd2, 8'd5, 8'd7, 8'd15, 8'd30, 8'd53, 8'd106
  };

  // Update broadcast from the front stage to the row of band cells.
  typedef struct packed {
    logic               valid;
    logic               eof;
    logic [BAND_W-1:0]  band;
    logic [LEVEL_W-1:0] level;
  } bin_upd_t;

endpackage

// File: src/spbm_bin_if.sv
// ----------------------------------------------------------------------------
// Bin channel
// Valid/ready channel that carries one spectrum bin per transaction.
// ----------------------------------------------------------------------------
interface spbm_bin_if
  import spbm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bin_index;
  logic [MAG_W-1:0] magnitude;
  logic             end_of_frame;

  modport source (output valid, bin_index, magnitude, end_of_frame, input ready);
  modport sink   (input valid, bin_index, magnitude, end_of_frame, output ready);
endinterface

// File: src/spbm_band_if.sv
// ----------------------------------------------------------------------------
// Band channel
// Valid/ready channel that carries one band intensity per transaction.
// ----------------------------------------------------------------------------
interface spbm_band_if
  import spbm_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [NUM_W-1:0] band_number;
  logic [INT_W-1:0] intensity;
  logic             last_band;

  modport source (output valid, band_number, intensity, last_band, input ready);
  modport sink   (input valid, band_number, intensity, last_band, output ready);
endinterface

// File: src/spectrum_band_peak_meter_core.sv
// ----------------------------------------------------------------------------
// Spectrum band peak meter
// Tracks per-band peak levels of a magnitude spectrum and reads them out
// as bar intensities at the end of each frame.
// ----------------------------------------------------------------------------
// Usage: bins enter on bin_i, one transaction per bin, and band results leave
// on band_o. The noise threshold is written through cfg_we_i / cfg_wdata_i.
// A bin is accepted every cycle while no frame end is pending or reading out.
// Each bin is registered in the front stage and updates its band cell in the
// next cycle. The bin marked end of frame starts the readout: the row of band
// cells shifts toward the head one band per cycle while band_o is not stalled,
// the head peak is turned into an intensity with one reciprocal multiply and
// loaded into the output register. The end-of-frame bin passes the front
// stage register and then sets the readout state, after which each readout
// step loads one band into the output register, BANDS bands in all.
// bin_i.ready is low from the end-of-frame transaction until the last band
// has entered the output register. A stall on band_o holds the output
// register and pauses the shift. The shift fills the row with zeros, which
// clears the peaks for the next frame. Reset clears all peaks, empties the
// output register and sets the threshold to 2000.
// ----------------------------------------------------------------------------
module spectrum_band_peak_meter_core
  import spbm_pkg::*;
#(
  parameter int unsigned BANDS  = 8,
  parameter int unsigned LEVELS = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  spbm_bin_if.sink         bin_i,
  spbm_band_if.source      band_o,
  input  logic             cfg_we_i,
  input  logic [MAG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W  = $clog2(BANDS);
  localparam int unsigned IMUL_W = 17;
  localparam int unsigned IPRD_W = LEVEL_W + IMUL_W;
  localparam logic [IMUL_W-1:0] IntMul = IMUL_W'(LEVELS * INT_RECIP);

  logic [MAG_W-1:0]   thresh_q;
  logic               accept;
  bin_upd_t           upd;
  logic               drain_q;
  logic               drain_d;
  logic [CNT_W-1:0]   cnt_q;
  logic [CNT_W-1:0]   cnt_d;
  logic               step;
  logic               last;
  logic [LEVEL_W-1:0] peaks [BANDS];
  logic [LEVEL_W-1:0] nexts [BANDS];
  logic [LEVEL_W-1:0] peak_m1;
  logic [IPRD_W-1:0]  int_prod;
  logic [INT_W-1:0]   inten;
  logic               out_valid_q;
  logic               out_valid_d;
  logic [NUM_W-1:0]   out_num_q;
  logic [INT_W-1:0]   out_int_q;
  logic               out_last_q;

  // Threshold register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
    end else if (cfg_we_i) begin
      thresh_q <= cfg_wdata_i;
    end
  end

  // Bins are held off while a frame end waits in the front stage or reads out.
  assign bin_i.ready = !drain_q && !(upd.eof);
  assign accept      = bin_i.valid && bin_i.ready;

  spbm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .bin_index_i    (bin_i.bin_index),
    .magnitude_i    (bin_i.magnitude),
    .end_of_frame_i (bin_i.end_of_frame),
    .threshold_i    (thresh_q),
    .upd_o          (upd)
  );

  // Readout steps whenever the output register is free or being emptied.
  assign step = drain_q && (!out_valid_q || band_o.ready);
  assign last = (cnt_q == CNT_W'(BANDS - 1));

  always_comb begin
    drain_d = drain_q;
    cnt_d   = cnt_q;
    if (upd.eof) begin
      drain_d = 1'b1;
    end else if (step) begin
      if (last) begin
        drain_d = 1'b0;
        cnt_d   = '0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drain_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      drain_q <= drain_d;
      cnt_q   <= cnt_d;
    end
  end

  // Row of band cells; the tail takes zeros during readout.
  for (genvar i = 0; i < BANDS; i++) begin : g_cell
    if (i == BANDS - 1) begin : g_tail
      assign nexts[i] = '0;
    end else begin : g_link
      assign nexts[i] = peaks[i+1];
    end

    spbm_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .upd_i       (upd),
      .shift_i     (step),
      .peak_next_i (nexts[i]),
      .peak_o      (peaks[i])
    );
  end

  // Intensity of the head peak: (peak - 1) * LEVELS / 199, zero for no peak.
  assign peak_m1  = peaks[0] - 1'b1;
  assign int_prod = IPRD_W'(peak_m1) * IPRD_W'(IntMul);
  assign inten    = (peaks[0] == '0) ? '0 : int_prod[INT_SHIFT +: INT_W];

  // Output register control.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (band_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_num_q  <= NUM_W'(cnt_q);
      out_int_q  <= inten;
      out_last_q <= last;
    end
  end

  assign band_o.valid       = out_valid_q;
  assign band_o.band_number = out_num_q;
  assign band_o.intensity   = out_int_q;
  assign band_o.last_band   = out_last_q;

endmodule

// File: src/spbm_front.sv
// ----------------------------------------------------------------------------
// Band peak meter front stage
// Qualifies a bin, finds its band and level, and registers the update.
// ----------------------------------------------------------------------------
module spbm_front
  import spbm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [IDX_W-1:0] bin_index_i,
  input  logic [MAG_W-1:0] magnitude_i,
  input  logic             end_of_frame_i,
  input  logic [MAG_W-1:0] threshold_i,
  output bin_upd_t         upd_o
);

  logic               use_bin;
  logic [BAND_W-1:0]  band;
  logic [LVL_X_W-1:0] lvl_x;
  logic [LVL_P_W-1:0] lvl_prod;
  logic [LEVEL_W-1:0] level;
  bin_upd_t           upd_q;

  // A bin counts only above the lowest bins and strictly above the threshold.
  assign use_bin = (bin_index_i >= FIRST_BIN) && (magnitude_i > threshold_i);

  // The edges are sorted, so the band is the number of edges the index exceeds.
  always_comb begin
    band = '0;
    for (int k = 0; k < NUM_EDGES; k++) begin
      if (bin_index_i > BAND_EDGES[k]) begin
        band = band + 1'b1;
      end
    end
  end

  // Level by reciprocal multiply on magnitude / 8; large magnitudes clamp.
  assign lvl_x    = magnitude_i[3 +: LVL_X_W];
  assign lvl_prod = LVL_P_W'(lvl_x) * LVL_P_W'(LEVEL_RECIP);

  always_comb begin
    if (magnitude_i >= LEVEL_SAT_MAG) begin
      level = LEVEL_MAX;
    end else begin
      level = lvl_prod[LEVEL_SHIFT +: LEVEL_W];
    end
  end

  // Update stage; the payload loads only on an accepted bin.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_q <= '0;
    end else begin
      upd_q.valid <= accept_i && use_bin;
      upd_q.eof   <= accept_i && end_of_frame_i;
      if (accept_i) begin
        upd_q.band  <= band;
        upd_q.level <= level;
      end
    end
  end

  assign upd_o = upd_q;

endmodule

// File: src/spbm_cell.sv
// ----------------------------------------------------------------------------
// Band peak cell
// Holds the peak level of one band; shifts toward the head during readout.
// ----------------------------------------------------------------------------
module spbm_cell
  import spbm_pkg::*;
#(
  parameter int unsigned CELL_ID = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bin_upd_t           upd_i,
  input  logic               shift_i,
  input  logic [LEVEL_W-1:0] peak_next_i,
  output logic [LEVEL_W-1:0] peak_o
);

  logic [LEVEL_W-1:0] peak_q;
  logic [LEVEL_W-1:0] peak_d;
  logic               hit;

  // Only the bands with index edges can ever be hit by a bin.
  assign hit = (CELL_ID < FIX_BANDS) && upd_i.valid &&
               (upd_i.band == BAND_W'(CELL_ID)) && (upd_i.level > peak_q);

  // Readout takes the neighbor's peak; otherwise keep the running maximum.
  always_comb begin
    if (shift_i) begin
      peak_d = peak_next_i;
    end else if (hit) begin
      peak_d = upd_i.level;
    end else begin
      peak_d = peak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
    end else begin
      peak_q <= peak_d;
    end
  end

  assign peak_o = peak_q;

endmodule
